// ----- hdl/pfba_pkg.sv -----
package pfba_pkg;

  localparam int unsigned FRAMES_DEF  = 4096;
  localparam int unsigned REGIONS_DEF = 4;
  localparam int unsigned REGIONS_MAX = 4;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned COUNT_W     = 21;
  localparam int unsigned END_W       = 22;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 21;
  localparam int unsigned CFG_REGS    = 2 * REGIONS_MAX;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_FRAME    = 2'd1,
    ST_RESERVED    = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic scan_start;
    logic scan_issue;
    logic alloc_check;
    logic free_read;
    logic free_check;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_op;
    logic issue_done;
    logic chk_valid;
    logic found;
    logic chk_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] ge_mask(input logic [BIT_W-1:0] b);
    ge_mask = {WORD_W{1'b1}} << b;
  endfunction

  function automatic logic [WORD_W-1:0] lt_mask(input logic [BIT_W-1:0] b);
    lt_mask = ~({WORD_W{1'b1}} << b);
  endfunction

endpackage

// ----- hdl/pfba_req_if.sv -----
interface pfba_req_if;
  import pfba_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [FRAME_W-1:0] frame_in;

  modport source (output valid, operation, frame_in, input ready);
  modport sink (input valid, operation, frame_in, output ready);
endinterface

// ----- hdl/pfba_rsp_if.sv -----
interface pfba_rsp_if;
  import pfba_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_out;
  logic [1:0]         status;

  modport source (output valid, frame_out, status, input ready);
  modport sink (input valid, frame_out, status, output ready);
endinterface

// ----- hdl/pfba_ram.sv -----
module pfba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/pfba_ctrl.sv -----
module pfba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfba_pkg::dp_stat_t stat,
  output pfba_pkg::dp_cmd_t  cmd
);
  import pfba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (stat.in_op == OP_FREE) begin
            state_next = S_FREE_RD;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        cmd.scan_issue  = !stat.issue_done;
        cmd.alloc_check = stat.chk_valid;
        if (stat.chk_valid && (stat.found || stat.chk_last)) begin
          state_next = S_DONE;
        end
      end
      S_FREE_RD: begin
        cmd.free_read = 1'b1;
        state_next    = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.free_check = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/pfba_dp.sv -----
module pfba_dp #(
  parameter int unsigned FRAMES  = pfba_pkg::FRAMES_DEF,
  parameter int unsigned REGIONS = pfba_pkg::REGIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pfba_pkg::dp_cmd_t                  cmd,
  output pfba_pkg::dp_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfba_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               req_op,
  input  logic [pfba_pkg::FRAME_W-1:0]       req_frame,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [pfba_pkg::FRAME_W-1:0]       rsp_frame,
  output pfba_pkg::status_t                  rsp_status
);
  import pfba_pkg::*;

  localparam int unsigned WORDS = (FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW    = $clog2(WORDS + 2);
  localparam int unsigned WIW   = END_W - BIT_W;
  localparam logic [WIW-1:0]   LIM_W = WIW'(FRAMES / WORD_W);
  localparam logic [BIT_W-1:0] LIM_B = BIT_W'(FRAMES % WORD_W);
  localparam logic [END_W-1:0] LIM   = END_W'(FRAMES);

  // region setup
  logic [FRAME_W-1:0] base  [REGIONS];
  logic [COUNT_W-1:0] count [REGIONS];
  logic [END_W-1:0]   top   [REGIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < REGIONS; r++) begin
        base[r]  <= '0;
        count[r] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(CFG_REGS))) begin
      for (int r = 0; r < REGIONS; r++) begin
        if (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(r)) begin
          if (cfg_index[0] == REG_BASE) begin
            base[r] <= cfg_data[FRAME_W-1:0];
          end else begin
            count[r] <= cfg_data[COUNT_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < REGIONS; r++) begin
      top[r] = END_W'(base[r]) + END_W'(count[r]);
    end
  end

  // item and scan state
  logic               op;
  logic [FRAME_W-1:0] frame;
  logic [FRAME_W-1:0] last_frame;
  logic [AW-1:0]      iss_addr;
  logic [AW-1:0]      iss_addr_next;
  logic [CW-1:0]      iss_cnt;
  logic [BIT_W-1:0]   start_bit;
  logic               chk_valid;
  logic               chk_last;
  logic [AW-1:0]      chk_addr;
  logic [WORD_W-1:0]  chk_mask;
  logic               free_ok;
  logic               free_ok_next;
  logic [FRAME_W-1:0] pend_frame;
  status_t            pend_status;

  logic [WORD_W-1:0]  use_mask;
  logic [WORD_W-1:0]  pos_mask;
  logic [WORD_W-1:0]  cand;
  logic [BIT_W-1:0]   enc;
  logic               found;
  logic [FRAME_W-1:0] found_frame;
  logic [AW-1:0]      free_addr;
  logic               free_bit;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_data;

  assign iss_addr_next = (iss_addr == AW'(WORDS - 1)) ? '0 : iss_addr + AW'(1);
  assign free_addr     = frame[AW+BIT_W-1:BIT_W];

  // usable frames of the word being read
  always_comb begin
    logic [WIW-1:0]    w;
    logic [WIW-1:0]    lo_w;
    logic [WIW-1:0]    hi_w;
    logic [WORD_W-1:0] lo_m;
    logic [WORD_W-1:0] hi_m;
    w        = WIW'(iss_addr);
    use_mask = '0;
    for (int r = 0; r < REGIONS; r++) begin
      lo_w = WIW'(base[r][FRAME_W-1:BIT_W]);
      hi_w = top[r][END_W-1:BIT_W];
      lo_m = (lo_w < w) ? '1 : ((lo_w == w) ? ge_mask(base[r][BIT_W-1:0]) : '0);
      hi_m = (hi_w > w) ? '1 : ((hi_w == w) ? lt_mask(top[r][BIT_W-1:0]) : '0);
      use_mask = use_mask | (lo_m & hi_m);
    end
    hi_m     = (LIM_W > w) ? '1 : ((LIM_W == w) ? lt_mask(LIM_B) : '0);
    use_mask = use_mask & hi_m;
  end

  always_comb begin
    priority if (iss_cnt == '0) begin
      pos_mask = ge_mask(start_bit);
    end else if (iss_cnt == CW'(WORDS)) begin
      pos_mask = lt_mask(start_bit);
    end else begin
      pos_mask = '1;
    end
  end

  always_comb begin
    free_ok_next = 1'b0;
    for (int r = 0; r < REGIONS; r++) begin
      if ((END_W'(frame) >= END_W'(base[r])) && (END_W'(frame) < top[r])) begin
        free_ok_next = 1'b1;
      end
    end
    free_ok_next = free_ok_next && (END_W'(frame) < LIM);
  end

  // lowest usable free frame of the returned word
  assign cand  = chk_mask & ~rd_data;
  assign found = chk_valid && (|cand);

  always_comb begin
    enc = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        enc = BIT_W'(i);
      end
    end
  end

  assign found_frame = FRAME_W'({chk_addr, enc});
  assign free_bit    = rd_data[frame[BIT_W-1:0]];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = iss_addr;
    wr_data = '0;
    priority if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_check && found) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr;
      wr_data = rd_data | (WORD_W'(1) << enc);
    end else if (cmd.free_check && free_ok && free_bit) begin
      wr_en   = 1'b1;
      wr_addr = free_addr;
      wr_data = rd_data & ~(WORD_W'(1) << frame[BIT_W-1:0]);
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_en   = cmd.scan_issue || cmd.free_read;
  assign rd_addr = cmd.free_read ? free_addr : iss_addr;

  pfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_addr   <= '0;
      iss_cnt    <= '0;
      chk_valid  <= 1'b0;
      last_frame <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      chk_valid <= cmd.scan_issue;
      if (cmd.clr_step) begin
        iss_addr <= iss_addr_next;
      end else if (cmd.scan_start) begin
        iss_addr <= last_frame[AW+BIT_W-1:BIT_W];
        iss_cnt  <= '0;
      end else if (cmd.scan_issue) begin
        iss_addr <= iss_addr_next;
        iss_cnt  <= iss_cnt + CW'(1);
      end
      if (cmd.alloc_check && found) begin
        last_frame <= found_frame;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op    <= req_op;
      frame <= req_frame;
    end
    if (cmd.scan_start) begin
      start_bit <= last_frame[BIT_W-1:0];
    end
    chk_addr <= iss_addr;
    chk_mask <= use_mask & pos_mask;
    chk_last <= (iss_cnt == CW'(WORDS));
    if (cmd.free_read) begin
      free_ok <= free_ok_next;
    end
    if (cmd.alloc_check) begin
      if (found) begin
        pend_frame  <= found_frame;
        pend_status <= ST_OK;
      end else if (chk_last) begin
        pend_frame  <= '0;
        pend_status <= ST_NO_FRAME;
      end
    end
    if (cmd.free_check) begin
      pend_frame <= '0;
      priority if (!free_ok) begin
        pend_status <= ST_RESERVED;
      end else if (!free_bit) begin
        pend_status <= ST_DOUBLE_FREE;
      end else begin
        pend_status <= ST_OK;
      end
    end
    if (cmd.out_load) begin
      rsp_frame  <= pend_frame;
      rsp_status <= pend_status;
    end
  end

  // op is kept for the free path decode of the held item
  assign stat.clr_last   = (iss_addr == AW'(WORDS - 1));
  assign stat.in_op      = req_op;
  assign stat.issue_done = (iss_cnt == CW'(WORDS + 1)) || (op == OP_FREE);
  assign stat.chk_valid  = chk_valid;
  assign stat.found      = found;
  assign stat.chk_last   = chk_last;
  assign stat.out_free   = !rsp_valid || rsp_ready;

endmodule

// ----- hdl/page_frame_bitmap_allocator.sv -----
// page frame allocator over a busy bitmap, one bit per frame, next-fit
//
// req channel (valid/ready): operation 0 allocates a frame, 1 frees frame_in.
// rsp channel (valid/ready): one transaction per request with frame_out and
// status (ok, out of frames, free of reserved frame, double free).
// configuration: cfg_we with cfg_index 0..7 writes base and frame count of
// regions 0..3 only while no request is outstanding: a user rule, unenforced.
//
// the bitmap sits in a ram of FRAMES/32 words. an allocate reads one word a
// cycle from the word holding the last allocated frame, wrapping round. one
// request is worked on at a time.
//
// after reset the bitmap is cleared one word a cycle, all FRAMES/32 words
// (128 at the default size), while req is held not ready.
// the response is held in an output register: a stall on rsp only delays the
// next request once that register is still full when the next result is due.
module page_frame_bitmap_allocator #(
  parameter int unsigned FRAMES  = pfba_pkg::FRAMES_DEF,
  parameter int unsigned REGIONS = pfba_pkg::REGIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  pfba_req_if.sink                        req,
  pfba_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  rsp_status;

  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfba_dp #(
    .FRAMES  (FRAMES),
    .REGIONS (REGIONS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_op     (req.operation),
    .req_frame  (req.frame_in),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_frame  (rsp.frame_out),
    .rsp_status (rsp_status)
  );

  assign rsp.status = rsp_status;

endmodule
